// ===== design/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg: shared types and codes for the generational handle table
// Request actions, result status codes and the layout of one slot entry.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

    // Request action codes
    typedef logic [2:0] t_action;

    localparam t_action ACT_ADD    = 3'd0;
    localparam t_action ACT_REMOVE = 3'd1;
    localparam t_action ACT_CHECK  = 3'd2;
    localparam t_action ACT_READ   = 3'd3;
    localparam t_action ACT_CLEAR  = 3'd4;

    // Result status codes
    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_STALE = 2'd2;

    // One slot as kept in the slot memory
    typedef struct packed {
        logic        occupied;
        logic [31:0] handle;
        logic [31:0] payload;
    } t_slot_entry;

endpackage

`default_nettype wire

// ===== design/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram: simple dual-port RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table: slot table issuing generational handles
// Add, remove, check, read and clear requests over a table of slots, with a
// LIFO free stack and a high-water mark for slot allocation.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy never rises, so
// one request per cycle is sustained. Each request yields exactly one result,
// loaded into the result register at the first clock edge after the request is
// taken and shown on the o_ ports for the single cycle that follows, with
// o_done high; the receiver cannot stall and must take it then.
// The stage after the input register reads the slot memory and the free-stack
// memory and performs their single write; results of one request are
// forwarded into the memory reads of the next, so back-to-back requests on the
// same slot see each other's effects. No clearing pass is needed after reset.
`default_nettype none

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT       = 256,
    parameter int INDEX_FIELD_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_action     i_action,
    input  wire logic [31:0] i_handle,
    input  wire logic [31:0] i_payload,
    output logic             o_done,
    output logic      [31:0] o_new_handle,
    output logic      [31:0] o_payload_out,
    output t_status          o_status
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int ENTRY_W = $bits(t_slot_entry);

    localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_FIELD_BITS) - 64'd1;
    localparam logic [63:0] ADD_LIMIT =
        (64'(SLOT_COUNT) < IDX_MASK) ? 64'(SLOT_COUNT) : IDX_MASK;
    localparam logic [CNT_W-1:0] HW_LIMIT = ADD_LIMIT[CNT_W-1:0];
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);

    // Table state
    logic [CNT_W-1:0] r_free_depth, n_free_depth;
    logic [CNT_W-1:0] r_high_water, n_high_water;
    logic [15:0]      r_generation, n_generation;

    // Input register stage
    logic              r_v;
    t_action           r_action;
    logic [31:0]       r_handle;
    logic [31:0]       r_payload;
    logic [IDX_W-1:0]  r_slot_idx;
    logic              r_in_range;
    logic              r_slot_hit;
    t_slot_entry       r_slot_fwd;
    logic              r_top_hit;
    logic [IDX_W-1:0]  r_top_fwd;

    // Result register stage
    logic              r_done, n_done;
    logic [31:0]       r_new_handle, n_new_handle;
    logic [31:0]       r_payload_out, n_payload_out;
    t_status           r_status, n_status;

    // Memory ports
    logic              w_slot_we;
    logic [IDX_W-1:0]  w_slot_waddr;
    t_slot_entry       w_slot_wdata;
    logic [IDX_W-1:0]  w_slot_raddr;
    t_slot_entry       w_slot_rdata;
    logic              w_stack_we;
    logic [IDX_W-1:0]  w_stack_waddr;
    logic [IDX_W-1:0]  w_stack_wdata;
    logic [IDX_W-1:0]  w_top_addr;
    logic [IDX_W-1:0]  w_stack_rdata;

    // Request decode and execute signals
    logic [31:0]       w_field;
    logic              w_in_range;
    t_slot_entry       w_slot;
    logic [IDX_W-1:0]  w_top;
    logic              w_live;
    logic              w_pop;
    logic              w_grow;
    logic [IDX_W-1:0]  w_add_idx;
    logic [15:0]       w_gen_inc;
    logic [63:0]       w_handle_wide;
    logic [31:0]       w_add_handle;

    assign busy = 1'b0;

    // Slot store: occupied flag, issued handle and payload per slot
    ght_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // Free stack of released slot indices
    ght_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stack_we),
        .i_waddr (w_stack_waddr),
        .i_wdata (w_stack_wdata),
        .i_raddr (w_top_addr),
        .o_rdata (w_stack_rdata)
    );

    // Decode the incoming handle against the state left by the request ahead
    assign w_field      = i_handle & IDX_MASK[31:0];
    assign w_slot_raddr = w_field[IDX_W-1:0];
    assign w_in_range   = w_field < 32'(n_high_water);
    assign w_top_addr   = IDX_W'(n_free_depth - CNT_W'(1));

    // Capture the request, plus forwarding of writes the memories miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= start;
        end
        r_action   <= i_action;
        r_handle   <= i_handle;
        r_payload  <= i_payload;
        r_slot_idx <= w_slot_raddr;
        r_in_range <= w_in_range;
        r_slot_hit <= w_slot_we && (w_slot_waddr == w_slot_raddr);
        r_slot_fwd <= w_slot_wdata;
        r_top_hit  <= w_stack_we && (w_stack_waddr == w_top_addr);
        r_top_fwd  <= w_stack_wdata;
    end

    // Merge forwarded data with memory read data
    assign w_slot = r_slot_hit ? r_slot_fwd : w_slot_rdata;
    assign w_top  = r_top_hit ? r_top_fwd : w_stack_rdata;
    assign w_live = r_in_range && w_slot.occupied && (w_slot.handle == r_handle);

    // Allocation: pop the free stack first, else grow past the high-water mark
    assign w_pop         = r_free_depth != '0;
    assign w_grow        = r_high_water < HW_LIMIT;
    assign w_add_idx     = w_pop ? w_top : r_high_water[IDX_W-1:0];
    assign w_gen_inc     = r_generation + 16'd1;
    assign w_handle_wide = ({48'd0, w_gen_inc} << INDEX_FIELD_BITS)
                         | {{(64 - IDX_W){1'b0}}, w_add_idx};
    assign w_add_handle  = w_handle_wide[31:0];

    // Execute one request
    always_comb begin
        n_free_depth  = r_free_depth;
        n_high_water  = r_high_water;
        n_generation  = r_generation;
        w_slot_we     = 1'b0;
        w_slot_waddr  = r_slot_idx;
        w_slot_wdata  = w_slot;
        w_stack_we    = 1'b0;
        w_stack_waddr = r_free_depth[IDX_W-1:0];
        w_stack_wdata = r_slot_idx;
        n_done        = r_v;
        n_new_handle  = 32'd0;
        n_payload_out = 32'd0;
        n_status      = STATUS_OK;
        if (r_v) begin
            case (r_action)
                ACT_ADD: begin
                    if (w_pop || w_grow) begin
                        if (w_pop) begin
                            n_free_depth = r_free_depth - CNT_W'(1);
                        end else begin
                            n_high_water = r_high_water + CNT_W'(1);
                        end
                        n_generation          = w_gen_inc;
                        w_slot_we             = 1'b1;
                        w_slot_waddr          = w_add_idx;
                        w_slot_wdata.occupied = 1'b1;
                        w_slot_wdata.handle   = w_add_handle;
                        w_slot_wdata.payload  = r_payload;
                        n_new_handle          = w_add_handle;
                    end else begin
                        n_status = STATUS_FULL;
                    end
                end
                ACT_REMOVE: begin
                    if (w_live && (r_free_depth < SLOTS)) begin
                        w_slot_we             = 1'b1;
                        w_slot_wdata.occupied = 1'b0;
                        w_stack_we            = 1'b1;
                        n_free_depth          = r_free_depth + CNT_W'(1);
                    end else begin
                        n_status = STATUS_STALE;
                    end
                end
                ACT_CHECK: begin
                    if (!w_live) begin
                        n_status = STATUS_STALE;
                    end
                end
                ACT_READ: begin
                    if (w_live) begin
                        n_payload_out = w_slot.payload;
                    end else begin
                        n_status = STATUS_STALE;
                    end
                end
                ACT_CLEAR: begin
                    n_free_depth = '0;
                    n_high_water = '0;
                    n_generation = 16'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance table state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_depth <= '0;
            r_high_water <= '0;
            r_generation <= 16'd0;
            r_done       <= 1'b0;
        end else begin
            r_free_depth <= n_free_depth;
            r_high_water <= n_high_water;
            r_generation <= n_generation;
            r_done       <= n_done;
        end
        r_new_handle  <= n_new_handle;
        r_payload_out <= n_payload_out;
        r_status      <= n_status;
    end

    assign o_done        = r_done;
    assign o_new_handle  = r_new_handle;
    assign o_payload_out = r_payload_out;
    assign o_status      = r_status;

endmodule

`default_nettype wire
